// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr)
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== rtl/core/dfpp_pkg.sv =====
// shared types and constants of the delimited field packet parser
// no dependencies
`default_nettype none
package dfpp_pkg;

  localparam int FIELD_TYPES = 16;
  localparam int ID_BYTES    = 4;
  localparam int COUNT_BYTES = 2;
  // id bytes that land in the 32-bit packet id
  localparam int ID_KEEP     = 4;
  localparam int ID_SEL_W    = $clog2(ID_KEEP);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] CFG_START_BYTE  = 3'd0;
  localparam logic [2:0] CFG_END_BYTE    = 3'd1;
  localparam logic [2:0] CFG_SIZES_LOW   = 3'd2;
  localparam logic [2:0] CFG_SIZES_HIGH  = 3'd3;

  localparam logic [2:0] EV_CONSUMED = 3'd0;
  localparam logic [2:0] EV_DATA     = 3'd1;
  localparam logic [2:0] EV_EMPTY    = 3'd2;
  localparam logic [2:0] EV_DONE     = 3'd3;
  localparam logic [2:0] EV_DROP     = 3'd4;
  localparam logic [2:0] EV_UNKNOWN  = 3'd5;

  // one classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_start;
    logic       is_end;
    logic       known;
    logic [7:0] size;
  } entry_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/dfpp_front.sv =====
// front end: configuration registers and per-byte classification
// depends on dfpp_pkg
`default_nettype none
module dfpp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [63:0]     cfg_wdata,
  input  wire logic [7:0]      rx_byte,
  output dfpp_pkg::entry_t     entry
);
  import dfpp_pkg::*;

  logic [7:0]  start_byte_r;
  logic [7:0]  end_byte_r;
  logic [63:0] sizes_low_r;
  logic [63:0] sizes_high_r;
  logic [63:0] size_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= '0;
      end_byte_r   <= '0;
      sizes_low_r  <= '0;
      sizes_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_START_BYTE: start_byte_r <= cfg_wdata[7:0];
        CFG_END_BYTE:   end_byte_r   <= cfg_wdata[7:0];
        CFG_SIZES_LOW:  sizes_low_r  <= cfg_wdata;
        CFG_SIZES_HIGH: sizes_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // size table lookup by the low type bits
  assign size_word = rx_byte[3] ? sizes_high_r : sizes_low_r;

  always_comb begin
    entry.data     = rx_byte;
    entry.is_start = (rx_byte == start_byte_r);
    entry.is_end   = (rx_byte == end_byte_r);
    entry.known    = (9'(rx_byte) < 9'(FIELD_TYPES));
    entry.size     = size_word[{rx_byte[2:0], 3'b000} +: 8];
  end

endmodule
`default_nettype wire

// ===== rtl/core/dfpp_queue.sv =====
// short fifo of classified bytes between front and back
// depends on dfpp_pkg
`default_nettype none
module dfpp_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire dfpp_pkg::entry_t push_entry,
  input  wire logic         pop,
  output dfpp_pkg::entry_t  head,
  output dfpp_pkg::q_stat_t stat
);
  import dfpp_pkg::*;

  entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign stat.count = count_r;

endmodule
`default_nettype wire

// ===== rtl/core/dfpp_back.sv =====
// back end: packet parse state machine and output register
// depends on dfpp_pkg
`default_nettype none
module dfpp_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire dfpp_pkg::entry_t  head,
  input  wire dfpp_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_event_res,
  output logic [31:0]       out_packet_id,
  output logic [7:0]        out_packet_kind,
  output logic [7:0]        out_field_kind,
  output logic [15:0]       out_field_number,
  output logic [7:0]        out_data_out,
  output logic [7:0]        out_byte_index,
  output logic              out_last_of_field
);
  import dfpp_pkg::*;

  localparam logic [2:0] PH_HUNT  = 3'd0;
  localparam logic [2:0] PH_ID    = 3'd1;
  localparam logic [2:0] PH_KIND  = 3'd2;
  localparam logic [2:0] PH_COUNT = 3'd3;
  localparam logic [2:0] PH_FTYPE = 3'd4;
  localparam logic [2:0] PH_FDATA = 3'd5;
  localparam logic [2:0] PH_END   = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] fin_r, fin_nxt;
  logic [7:0]  fkind_r, fkind_nxt;
  logic [7:0]  bip_r, bip_nxt;
  logic [7:0]  plen_r, plen_nxt;

  logic [15:0] fin_inc;
  logic [7:0]  bip_inc;
  logic [15:0] exp_upd;
  logic [2:0]  ev;
  logic [7:0]  dout;
  logic [7:0]  bidx;
  logic        last;
  logic [15:0] fnum;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  ev_r;
  logic [31:0] oid_r;
  logic [7:0]  okind_r;
  logic [7:0]  ofkind_r;
  logic [15:0] fnum_r;
  logic [7:0]  dout_r;
  logic [7:0]  bidx_r;
  logic        last_r;

  // take a beat from the queue whenever the output register is free or draining
  assign pop     = !q_stat.empty && (!out_valid_r || !out_stall);
  assign fin_inc = fin_r + 16'd1;
  assign bip_inc = bip_r + 8'd1;

  always_comb begin
    exp_upd = exp_r;
    if (bip_r < 8'(COUNT_BYTES)) begin
      exp_upd = exp_r | (16'(head.data) << {bip_r[0], 3'b000});
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    id_nxt    = id_r;
    kind_nxt  = kind_r;
    exp_nxt   = exp_r;
    fin_nxt   = fin_r;
    fkind_nxt = fkind_r;
    bip_nxt   = bip_r;
    plen_nxt  = plen_r;
    ev        = EV_CONSUMED;
    dout      = '0;
    bidx      = '0;
    last      = 1'b0;
    fnum      = fin_r;
    unique case (phase_r)
      PH_HUNT: begin
        if (head.is_start) begin
          id_nxt    = '0;
          kind_nxt  = '0;
          exp_nxt   = '0;
          fin_nxt   = '0;
          fkind_nxt = '0;
          bip_nxt   = '0;
          plen_nxt  = '0;
          fnum      = '0;
          phase_nxt = PH_ID;
        end else begin
          ev = EV_DROP;
        end
      end
      PH_ID: begin
        if (bip_r < 8'(ID_KEEP)) begin
          id_nxt = id_r | (32'(head.data) << {bip_r[ID_SEL_W-1:0], 3'b000});
        end
        if (bip_inc >= 8'(ID_BYTES)) begin
          bip_nxt   = '0;
          phase_nxt = PH_KIND;
        end else begin
          bip_nxt = bip_inc;
        end
      end
      PH_KIND: begin
        kind_nxt  = head.data;
        phase_nxt = PH_COUNT;
      end
      PH_COUNT: begin
        exp_nxt = exp_upd;
        if (bip_inc >= 8'(COUNT_BYTES)) begin
          bip_nxt   = '0;
          phase_nxt = (exp_upd == '0) ? PH_END : PH_FTYPE;
        end else begin
          bip_nxt = bip_inc;
        end
      end
      PH_FTYPE: begin
        fkind_nxt = head.data;
        if (!head.known) begin
          ev        = EV_UNKNOWN;
          phase_nxt = PH_HUNT;
        end else begin
          plen_nxt = head.size;
          bip_nxt  = '0;
          if (head.size == '0) begin
            ev        = EV_EMPTY;
            fin_nxt   = fin_inc;
            phase_nxt = (fin_inc == exp_r) ? PH_END : PH_FTYPE;
          end else begin
            phase_nxt = PH_FDATA;
          end
        end
      end
      PH_FDATA: begin
        ev   = EV_DATA;
        dout = head.data;
        bidx = bip_r;
        if (bip_inc >= plen_r) begin
          last      = 1'b1;
          bip_nxt   = '0;
          fin_nxt   = fin_inc;
          phase_nxt = (fin_inc == exp_r) ? PH_END : PH_FTYPE;
        end else begin
          bip_nxt = bip_inc;
        end
      end
      PH_END: begin
        if (head.is_end) begin
          ev        = EV_DONE;
          phase_nxt = PH_HUNT;
        end else begin
          ev = EV_DROP;
        end
      end
      default: begin
        ev        = EV_DROP;
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      id_r        <= '0;
      kind_r      <= '0;
      exp_r       <= '0;
      fin_r       <= '0;
      fkind_r     <= '0;
      bip_r       <= '0;
      plen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        id_r    <= id_nxt;
        kind_r  <= kind_nxt;
        exp_r   <= exp_nxt;
        fin_r   <= fin_nxt;
        fkind_r <= fkind_nxt;
        bip_r   <= bip_nxt;
        plen_r  <= plen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_r     <= ev;
      oid_r    <= id_nxt;
      okind_r  <= kind_nxt;
      ofkind_r <= fkind_nxt;
      fnum_r   <= fnum;
      dout_r   <= dout;
      bidx_r   <= bidx;
      last_r   <= last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_packet_id     = oid_r;
  assign out_packet_kind   = okind_r;
  assign out_field_kind    = ofkind_r;
  assign out_field_number  = fnum_r;
  assign out_data_out      = dout_r;
  assign out_byte_index    = bidx_r;
  assign out_last_of_field = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/delimited_field_packet_parser.sv =====
// Delimited field packet parser. Takes one received byte per beat and gives one
// result per byte: hunts for start_byte, gathers a little-endian id, a packet type
// and a little-endian field count, then walks the fields (type byte plus the
// configured number of data bytes) and waits for end_byte. Sustains one byte per clock
// while out_stall is low; an accepted byte is queued and its result is registered onto
// out_valid when dfpp_back pops it. A four-beat queue between the classifying front and
// the parse state machine takes up to four more bytes while out_stall holds a result.
// Depends on dfpp_pkg, dfpp_front, dfpp_queue, dfpp_back and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module delimited_field_packet_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [31:0]      out_packet_id,
  output logic [7:0]       out_packet_kind,
  output logic [7:0]       out_field_kind,
  output logic [15:0]      out_field_number,
  output logic [7:0]       out_data_out,
  output logic [7:0]       out_byte_index,
  output logic             out_last_of_field,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import dfpp_pkg::*;

  entry_t  front_entry;
  entry_t  q_head;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  dfpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rx_byte   (in_rx_byte),
    .entry     (front_entry)
  );

  dfpp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  dfpp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .q_stat            (q_stat),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_packet_id     (out_packet_id),
    .out_packet_kind   (out_packet_kind),
    .out_field_kind    (out_field_kind),
    .out_field_number  (out_field_number),
    .out_data_out      (out_data_out),
    .out_byte_index    (out_byte_index),
    .out_last_of_field (out_last_of_field)
  );

  // queue occupancy stays within its depth
  `ASSERT_ALWAYS(a_q_count, clk, rst_n, q_stat.count <= Q_CNT_W'(Q_DEPTH))
  // the back end only pops a queue that holds a beat
  `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, q_pop, !q_stat.empty)
  // data fields are zero unless the result carries a field byte
  `ASSERT_IMPLIES(a_data_only, clk, rst_n, out_valid && (out_event_res != EV_DATA),
    (out_data_out == 8'd0) && (out_byte_index == 8'd0) && !out_last_of_field)

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for delimited_field_packet_parser: directed and random byte streams
// are predicted in step with the accepted beats and compared against every result beat
// depends on dfpp_pkg and the delimited_field_packet_parser rtl
module tb_top;
  import dfpp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 125;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE      = 8;

  localparam logic [2:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

  // noise, a zero-count packet closed after noise, then empty, one-byte and unknown fields
  localparam logic [7:0] DIRECTED [24] = '{
    8'h00, 8'hFF, 8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h11, 8'h5A,
    8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h0F, 8'h80, 8'hFF
  };

  typedef enum logic [2:0] {
    ST_HUNT, ST_ID, ST_KIND, ST_COUNT, ST_FTYPE, ST_FDATA, ST_END
  } parse_state_e;

  typedef struct packed {
    logic [2:0]  ev;
    logic [31:0] id;
    logic [7:0]  pkt_kind;
    logic [7:0]  fld_kind;
    logic [15:0] fld_num;
    logic [7:0]  data;
    logic [7:0]  idx;
    logic        last;
  } parse_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [31:0] out_packet_id;
  logic [7:0]  out_packet_kind;
  logic [7:0]  out_field_kind;
  logic [15:0] out_field_number;
  logic [7:0]  out_data_out;
  logic [7:0]  out_byte_index;
  logic        out_last_of_field;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_wdata = 64'd0;

  // register copies and parser state after reset
  logic [7:0]   start_code = 8'h00;
  logic [7:0]   stop_code = 8'h00;
  logic [63:0]  len_lo = 64'd0;
  logic [63:0]  len_hi = 64'd0;
  parse_state_e parse_st = ST_HUNT;
  logic [31:0]  pkt_id = 32'd0;
  logic [7:0]   pkt_kind = 8'h00;
  logic [15:0]  fields_due = 16'd0;
  logic [15:0]  fields_done = 16'd0;
  logic [7:0]   fld_kind = 8'h00;
  logic [7:0]   part_pos = 8'h00;
  logic [7:0]   part_len = 8'h00;

  logic [7:0]    bytes_pending [$];
  parse_result_t results_due [$];
  int            send_idle_pct = 0;
  int            rx_stall_pct = 0;
  int            err_count = 0;
  int            cycle_count = 0;

  delimited_field_packet_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_packet_id     (out_packet_id),
    .out_packet_kind   (out_packet_kind),
    .out_field_kind    (out_field_kind),
    .out_field_number  (out_field_number),
    .out_data_out      (out_data_out),
    .out_byte_index    (out_byte_index),
    .out_last_of_field (out_last_of_field),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic logic [7:0] type_len(input logic [3:0] t);
    logic [63:0] sizes;
    sizes = t[3] ? len_hi : len_lo;
    return sizes[8 * t[2:0] +: 8];
  endfunction

  function automatic void close_field();
    fields_done = fields_done + 16'd1;
    parse_st = (fields_done == fields_due) ? ST_END : ST_FTYPE;
  endfunction

  // advances the parser copy by one byte and returns the result it should report
  function automatic parse_result_t parse_byte(input logic [7:0] b);
    parse_result_t r;
    logic [15:0]   done_before;
    r = '0;
    r.ev = EV_CONSUMED;
    done_before = fields_done;
    case (parse_st)
      ST_HUNT: begin
        if (b == start_code) begin
          pkt_id = '0;
          pkt_kind = '0;
          fields_due = '0;
          fields_done = '0;
          fld_kind = '0;
          part_pos = '0;
          part_len = '0;
          parse_st = ST_ID;
        end else begin
          r.ev = EV_DROP;
        end
      end
      ST_ID: begin
        // id bytes past the kept width are swallowed
        if (part_pos < ID_KEEP) pkt_id = pkt_id | (32'(b) << (8 * part_pos));
        part_pos = part_pos + 8'd1;
        if (part_pos >= ID_BYTES) begin
          part_pos = '0;
          parse_st = ST_KIND;
        end
      end
      ST_KIND: begin
        pkt_kind = b;
        parse_st = ST_COUNT;
      end
      ST_COUNT: begin
        if (part_pos < 2) fields_due = fields_due | (16'(b) << (8 * part_pos));
        part_pos = part_pos + 8'd1;
        if (part_pos >= COUNT_BYTES) begin
          part_pos = '0;
          parse_st = (fields_due == 16'd0) ? ST_END : ST_FTYPE;
        end
      end
      ST_FTYPE: begin
        fld_kind = b;
        if (b >= FIELD_TYPES) begin
          r.ev = EV_UNKNOWN;
          parse_st = ST_HUNT;
        end else begin
          part_len = type_len(b[3:0]);
          part_pos = '0;
          if (part_len == 8'd0) begin
            r.ev = EV_EMPTY;
            close_field();
          end else begin
            parse_st = ST_FDATA;
          end
        end
      end
      ST_FDATA: begin
        r.ev = EV_DATA;
        r.data = b;
        r.idx = part_pos;
        part_pos = part_pos + 8'd1;
        if (part_pos >= part_len) begin
          r.last = 1'b1;
          part_pos = '0;
          close_field();
        end
      end
      ST_END: begin
        if (b == stop_code) begin
          r.ev = EV_DONE;
          parse_st = ST_HUNT;
        end else begin
          r.ev = EV_DROP;
        end
      end
      default: begin
        r.ev = EV_DROP;
        parse_st = ST_HUNT;
      end
    endcase
    r.id = pkt_id;
    r.pkt_kind = pkt_kind;
    r.fld_kind = fld_kind;
    // a field that closes on this byte still reports its own number
    r.fld_num = (r.ev == EV_EMPTY || r.last) ? done_before : fields_done;
    return r;
  endfunction

  // input side: predict on every accepted beat, then offer the next byte or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) results_due.push_back(parse_byte(in_rx_byte));
      if (!in_valid || !in_stall) begin
        if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= bytes_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result();
    parse_result_t want;
    parse_result_t got;
    got = '{out_event_res, out_packet_id, out_packet_kind, out_field_kind,
            out_field_number, out_data_out, out_byte_index, out_last_of_field};
    if (results_due.size() == 0) begin
      if (err_count < MAX_REPORTS)
        $display("unexpected result beat: ev=%0d id=%h", got.ev, got.id);
      err_count++;
    end else begin
      want = results_due.pop_front();
      if (got !== want) begin
        if (err_count < MAX_REPORTS) begin
          $display("mismatch expected: ev=%0d id=%h pk=%h fk=%h fn=%0d d=%h bi=%0d last=%b",
                   want.ev, want.id, want.pkt_kind, want.fld_kind, want.fld_num,
                   want.data, want.idx, want.last);
          $display("         actual:   ev=%0d id=%h pk=%h fk=%h fn=%0d d=%h bi=%0d last=%b",
                   got.ev, got.id, got.pkt_kind, got.fld_kind, got.fld_num,
                   got.data, got.idx, got.last);
        end
        err_count++;
      end
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) check_result();
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_START_BYTE: start_code = val[7:0];
      CFG_END_BYTE:   stop_code = val[7:0];
      CFG_SIZES_LOW:  len_lo = val;
      CFG_SIZES_HIGH: len_hi = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] start_v, input logic [7:0] stop_v,
                            input logic [63:0] lo_v, input logic [63:0] hi_v);
    write_reg(CFG_START_BYTE, {56'd0, start_v});
    write_reg(CFG_END_BYTE, {56'd0, stop_v});
    write_reg(CFG_SIZES_LOW, lo_v);
    write_reg(CFG_SIZES_HIGH, hi_v);
    // unmapped index must leave everything alone
    write_reg(3'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)), {$urandom, $urandom});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_pending.size() != 0 || in_valid || results_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] small_sizes();
    logic [63:0] s;
    for (int k = 0; k < 8; k++) s[8 * k +: 8] = 8'($urandom_range(5));
    return s;
  endfunction

  // one packet, mostly well formed; some carry a huge count cut short by an unknown
  // field type, some are truncated anywhere
  function automatic int add_packet(input int max_fields);
    logic [7:0] pkt [$];
    logic [7:0] b;
    logic [7:0] ftype;
    int         n_fields;
    int         to_send;
    int         cut;
    bit         huge;
    bit         aborted;
    aborted = 1'b0;
    repeat ($urandom_range(2)) begin
      b = 8'($urandom);
      if (b == start_code) b = ~b;
      pkt.push_back(b);
    end
    pkt.push_back(start_code);
    repeat (ID_BYTES) pkt.push_back(8'($urandom));
    pkt.push_back(8'($urandom));
    huge = ($urandom_range(99) < 10);
    n_fields = huge ? $urandom_range(65535, 3) : $urandom_range(max_fields);
    pkt.push_back(n_fields[7:0]);
    pkt.push_back(n_fields[15:8]);
    to_send = huge ? $urandom_range(2) : n_fields;
    for (int i = 0; i < to_send && !aborted; i++) begin
      if ($urandom_range(99) < 5) begin
        pkt.push_back(8'($urandom_range(255, FIELD_TYPES)));
        aborted = 1'b1;
      end else begin
        ftype = 8'($urandom_range(FIELD_TYPES - 1));
        pkt.push_back(ftype);
        repeat (type_len(ftype[3:0])) pkt.push_back(8'($urandom));
      end
    end
    if (huge && !aborted) begin
      pkt.push_back(8'($urandom_range(255, FIELD_TYPES)));
      aborted = 1'b1;
    end
    if (!aborted) begin
      repeat ($urandom_range(2)) begin
        b = 8'($urandom);
        if (b == stop_code) b = ~b;
        pkt.push_back(b);
      end
      pkt.push_back(stop_code);
    end
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(pkt.size() - 1, 1);
      while (pkt.size() > cut) b = pkt.pop_back();
    end
    foreach (pkt[i]) bytes_pending.push_back(pkt[i]);
    return pkt.size();
  endfunction

  initial begin
    int added;
    int max_fields;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_config(8'hA5, 8'h5A, 64'h0101_0101_0101_0200, 64'h0101_0101_0101_0101);
    foreach (DIRECTED[i]) bytes_pending.push_back(DIRECTED[i]);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin send_idle_pct = 70; rx_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin send_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      case (p)
        0: set_config(8'h00, 8'hFF, small_sizes(), small_sizes());
        1: set_config(8'hFF, 8'h00, 64'd0, 64'd0);
        2: set_config(8'($urandom), 8'($urandom), '1, small_sizes());
        3: set_config(8'($urandom), 8'($urandom), small_sizes(), '1);
        default: set_config(8'($urandom), 8'($urandom), small_sizes(), small_sizes());
      endcase
      // full-length fields are slow, so keep those packets short
      max_fields = (p == 2 || p == 3) ? 2 : 4;
      added = 0;
      while (added < PHASE_ITEMS) added += add_packet(max_fields);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("delimited_field_packet_parser verification clean");
    end else begin
      $display("delimited_field_packet_parser verification failed");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("delimited_field_packet_parser verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dfpp_pkg.sv
rtl/core/dfpp_front.sv
rtl/core/dfpp_queue.sv
rtl/core/dfpp_back.sv
rtl/core/delimited_field_packet_parser.sv
test/tb_top.sv
